@@ hdl/wls_pkg.sv @@
// Shared types and constants of the weighted Laplacian stencil unit.
package wls_pkg;

    localparam int WEIGHT_W      = 16;
    localparam int RESULT_W      = 36;
    localparam int TAG_W         = 10;
    localparam int CFG_DATA_W    = 11;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_RESET_DIM = 1024;
    localparam int FIFO_DEPTH    = 4;
    localparam int OUT_TDATA_W   = ((RESULT_W + 2 * TAG_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    // Control half of one stencil task: which terms apply and where it sits.
    typedef struct packed {
        logic             en_right;
        logic             en_left;
        logic             en_down;
        logic             en_up;
        logic [TAG_W-1:0] row;
        logic [TAG_W-1:0] col;
        logic             done;
    } t_task_ctl;

endpackage

@@ hdl/wls_front.sv @@
// Front end: position tracking, two-row line buffers and task generation.
module wls_front import wls_pkg::*; #(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]                      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]                     i_cfg_data,
    input  logic                                      i_in_valid,
    output logic                                      o_in_ready,
    input  logic [SAMPLE_BITS-1:0]                    i_sample,
    input  logic [WEIGHT_W-1:0]                       i_weight,
    output logic                                      o_task_valid,
    input  logic                                      i_task_ready,
    output t_task_ctl                                 o_task_ctl,
    output logic [5*SAMPLE_BITS+3*WEIGHT_W-1:0]       o_task_opnd
);

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int ENTRY_W = SAMPLE_BITS + WEIGHT_W;
    localparam logic [COL_W-1:0] DEF_LAST_COL =
        COL_W'(((MAX_WIDTH < CFG_RESET_DIM) ? MAX_WIDTH : CFG_RESET_DIM) - 1);
    localparam logic [ROW_W-1:0] DEF_LAST_ROW =
        ROW_W'(((MAX_HEIGHT < CFG_RESET_DIM) ? MAX_HEIGHT : CFG_RESET_DIM) - 1);

    // One-hot task kinds, in the order they leave for one pixel.
    localparam logic [2:0] TASK_UP    = 3'b001;
    localparam logic [2:0] TASK_LAST  = 3'b010;
    localparam logic [2:0] TASK_FINAL = 3'b100;

    function automatic logic [COL_W-1:0] last_col_of(input logic [CFG_DATA_W-1:0] v);
        logic [COL_W-1:0] res;
        if (v == '0) begin
            res = '0;
        end else if (int'(v) > MAX_WIDTH) begin
            res = COL_W'(MAX_WIDTH - 1);
        end else begin
            res = COL_W'(v - 1'b1);
        end
        return res;
    endfunction

    function automatic logic [ROW_W-1:0] last_row_of(input logic [CFG_DATA_W-1:0] v);
        logic [ROW_W-1:0] res;
        if (v == '0) begin
            res = '0;
        end else if (int'(v) > MAX_HEIGHT) begin
            res = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            res = ROW_W'(v - 1'b1);
        end
        return res;
    endfunction

    logic [COL_W-1:0]   r_last_col;
    logic [ROW_W-1:0]   r_last_row;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic               cfg_hit;
    logic               in_acc;
    logic               col_last;
    logic               row_last;
    logic [COL_W-1:0]   col_plus;
    logic [COL_W-1:0]   addr0;
    logic [COL_W-1:0]   addr1;
    logic [ENTRY_W-1:0] wr_entry;

    logic [ENTRY_W-1:0] r_bank0 [MAX_WIDTH];
    logic [ENTRY_W-1:0] r_bank1 [MAX_WIDTH];
    logic [ENTRY_W-1:0] r_rd0;
    logic [ENTRY_W-1:0] r_rd1;

    logic                   r_p_valid;
    logic [ROW_W-1:0]       r_p_row;
    logic [COL_W-1:0]       r_p_col;
    logic                   r_p_last_c;
    logic                   r_p_last_r;
    logic [SAMPLE_BITS-1:0] r_p_s;
    logic [WEIGHT_W-1:0]    r_p_w;
    logic [2:0]             r_taken;

    logic [SAMPLE_BITS-1:0] r_ahead_s, r_left_s, r_h1_s, r_h2_s, r_rs_s;
    logic [WEIGHT_W-1:0]    r_ahead_w, r_left_w, r_h1_w, r_h2_w, r_rs_w;

    logic [ENTRY_W-1:0]     old_entry;
    logic [ENTRY_W-1:0]     ahead_entry;
    logic                   first_col;
    logic                   top_row;
    logic [SAMPLE_BITS-1:0] ctr_s;
    logic [WEIGHT_W-1:0]    ctr_w;
    logic [2:0]             need;
    logic [2:0]             pending;
    logic [2:0]             cur;
    logic                   only_one;
    logic                   push;
    logic                   finish;

    logic [SAMPLE_BITS-1:0] c_s, r_s, l_s, d_s, u_s;
    logic [WEIGHT_W-1:0]    c_w, l_w, u_w;

    assign cfg_hit  = i_cfg_valid &&
                      (i_cfg_index == REG_FRAME_WIDTH || i_cfg_index == REG_FRAME_HEIGHT);
    assign in_acc   = i_in_valid && o_in_ready;
    assign col_last = (r_col == r_last_col);
    assign row_last = (r_row == r_last_row);
    assign col_plus = r_col + 1'b1;
    // The bank holding this row's parity returns row r-2 at this column; the
    // other bank returns the previous row one column ahead.
    assign addr0    = r_row[0] ? col_plus : r_col;
    assign addr1    = r_row[0] ? r_col : col_plus;
    assign wr_entry = {i_weight, i_sample};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col <= DEF_LAST_COL;
            r_last_row <= DEF_LAST_ROW;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:  r_last_col <= last_col_of(i_cfg_data);
                REG_FRAME_HEIGHT: r_last_row <= last_row_of(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_hit) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            if (!col_last) begin
                r_col <= col_plus;
            end else begin
                r_col <= '0;
                r_row <= row_last ? '0 : r_row + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd0 <= r_bank0[addr0];
            if (!r_row[0]) begin
                r_bank0[r_col] <= wr_entry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd1 <= r_bank1[addr1];
            if (r_row[0]) begin
                r_bank1[r_col] <= wr_entry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_p_row    <= r_row;
            r_p_col    <= r_col;
            r_p_last_c <= col_last;
            r_p_last_r <= row_last;
            r_p_s      <= i_sample;
            r_p_w      <= i_weight;
        end
    end

    assign old_entry   = r_p_row[0] ? r_rd1 : r_rd0;
    assign ahead_entry = r_p_row[0] ? r_rd0 : r_rd1;
    assign first_col   = (r_p_col == '0);
    assign top_row     = (r_p_row == '0);
    // Previous row at this column: from the look-ahead read, or from the
    // row-start copy at column zero.
    assign ctr_s       = first_col ? r_rs_s : r_ahead_s;
    assign ctr_w       = first_col ? r_rs_w : r_ahead_w;

    assign need     = {r_p_last_r && r_p_last_c, r_p_last_r && !first_col, !top_row};
    assign pending  = need & ~r_taken;
    assign cur      = pending & 3'(~pending + 3'd1);
    assign only_one = ((pending & ~cur) == 3'b000);

    assign o_task_valid = r_p_valid && (pending != 3'b000);
    assign push         = o_task_valid && i_task_ready;
    assign finish       = r_p_valid && ((pending == 3'b000) || (push && only_one));
    assign o_in_ready   = !r_p_valid || finish;

    always_comb begin
        o_task_ctl = '0;
        c_s = r_p_s;
        c_w = r_p_w;
        r_s = r_p_s;
        l_s = r_h1_s;
        l_w = r_h1_w;
        d_s = r_p_s;
        u_s = ctr_s;
        u_w = ctr_w;
        case (cur)
            TASK_UP: begin
                o_task_ctl.en_right = !r_p_last_c;
                o_task_ctl.en_left  = !first_col;
                o_task_ctl.en_down  = 1'b1;
                o_task_ctl.en_up    = (r_p_row != ROW_W'(1));
                o_task_ctl.row      = TAG_W'(r_p_row - 1'b1);
                o_task_ctl.col      = TAG_W'(r_p_col);
                c_s = ctr_s;
                c_w = ctr_w;
                r_s = ahead_entry[SAMPLE_BITS-1:0];
                l_s = r_left_s;
                l_w = r_left_w;
                u_s = old_entry[SAMPLE_BITS-1:0];
                u_w = old_entry[ENTRY_W-1:SAMPLE_BITS];
            end
            TASK_LAST: begin
                o_task_ctl.en_right = 1'b1;
                o_task_ctl.en_left  = (r_p_col != COL_W'(1));
                o_task_ctl.en_up    = !top_row;
                o_task_ctl.row      = TAG_W'(r_p_row);
                o_task_ctl.col      = TAG_W'(r_p_col - 1'b1);
                c_s = r_h1_s;
                c_w = r_h1_w;
                l_s = r_h2_s;
                l_w = r_h2_w;
                u_s = r_left_s;
                u_w = r_left_w;
            end
            TASK_FINAL: begin
                o_task_ctl.en_left = !first_col;
                o_task_ctl.en_up   = !top_row;
                o_task_ctl.row     = TAG_W'(r_p_row);
                o_task_ctl.col     = TAG_W'(r_p_col);
                o_task_ctl.done    = 1'b1;
            end
            default: ;
        endcase
    end

    assign o_task_opnd = {u_w, l_w, c_w, u_s, d_s, l_s, r_s, c_s};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_taken   <= 3'b000;
        end else begin
            if (in_acc) begin
                r_p_valid <= 1'b1;
            end else if (finish) begin
                r_p_valid <= 1'b0;
            end
            if (finish) begin
                r_taken <= 3'b000;
            end else if (push) begin
                r_taken <= r_taken | cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_ahead_s <= ahead_entry[SAMPLE_BITS-1:0];
            r_ahead_w <= ahead_entry[ENTRY_W-1:SAMPLE_BITS];
            r_left_s  <= ctr_s;
            r_left_w  <= ctr_w;
            r_h2_s    <= r_h1_s;
            r_h2_w    <= r_h1_w;
            r_h1_s    <= r_p_s;
            r_h1_w    <= r_p_w;
            if (first_col) begin
                r_rs_s <= r_p_s;
                r_rs_w <= r_p_w;
            end
        end
    end

    a_cfg_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_hit |=> (r_row == '0 && r_col == '0))
        else $error("frame position not cleared by register write");

    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= r_last_col) && (r_row <= r_last_row))
        else $error("frame position outside configured frame");

endmodule

@@ hdl/wls_fifo.sv @@
// Short task queue between the front end and the arithmetic back end.
module wls_fifo import wls_pkg::*; #(
    parameter int DATA_W = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_task_ctl         i_push_ctl,
    input  logic [DATA_W-1:0] i_push_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output t_task_ctl         o_pop_ctl,
    output logic [DATA_W-1:0] o_pop_data
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_task_ctl         r_ctl_q  [FIFO_DEPTH];
    logic [DATA_W-1:0] r_data_q [FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full     = (r_count == CNT_W'(FIFO_DEPTH));
    assign o_empty    = (r_count == '0);
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && !o_empty;
    assign o_pop_ctl  = r_ctl_q[r_rd_ptr];
    assign o_pop_data = r_data_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_ctl_q[r_wr_ptr]  <= i_push_ctl;
            r_data_q[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_DEPTH))
        else $error("task queue overfilled");

    a_count_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("task queue lost a request");

endmodule

@@ hdl/wls_back.sv @@
// Back end: differences, four weighted products and the exact sum.
module wls_back import wls_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_task_valid,
    output logic                                o_task_pop,
    input  t_task_ctl                           i_task_ctl,
    input  logic [5*SAMPLE_BITS+3*WEIGHT_W-1:0] i_task_opnd,
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output logic [RESULT_W-1:0]                 o_result,
    output logic [TAG_W-1:0]                    o_row,
    output logic [TAG_W-1:0]                    o_col,
    output logic                                o_done
);

    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int PROD_W = DIFF_W + WEIGHT_W + 1;
    localparam int ACC_W  = PROD_W + 2;

    logic signed [SAMPLE_BITS-1:0] c_s, r_s, l_s, d_s, u_s;
    logic [WEIGHT_W-1:0]           c_w, l_w, u_w;
    logic                          en;

    logic                     r_s1_valid;
    t_task_ctl                r_s1_ctl;
    logic signed [DIFF_W-1:0] r_dr, r_dl, r_dd, r_du;
    logic [WEIGHT_W-1:0]      r_s1_cw, r_s1_lw, r_s1_uw;

    logic                     r_s2_valid;
    t_task_ctl                r_s2_ctl;
    logic signed [PROD_W-1:0] r_pr, r_pl, r_pd, r_pu;

    logic                     r_s3_valid;
    logic [RESULT_W-1:0]      r_s3_result;
    logic [TAG_W-1:0]         r_s3_row;
    logic [TAG_W-1:0]         r_s3_col;
    logic                     r_s3_done;

    logic signed [ACC_W-1:0]  acc;

    assign {u_w, l_w, c_w, u_s, d_s, l_s, r_s, c_s} = i_task_opnd;

    // The whole pipe moves together whenever the output register can move.
    assign en         = !r_s3_valid || i_res_ready;
    assign o_task_pop = en && i_task_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_task_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_ctl <= i_task_ctl;
            r_dr     <= DIFF_W'(r_s) - DIFF_W'(c_s);
            r_dl     <= DIFF_W'(c_s) - DIFF_W'(l_s);
            r_dd     <= DIFF_W'(d_s) - DIFF_W'(c_s);
            r_du     <= DIFF_W'(c_s) - DIFF_W'(u_s);
            r_s1_cw  <= c_w;
            r_s1_lw  <= l_w;
            r_s1_uw  <= u_w;
        end
    end

    // The zero arm is kept signed so the products stay signed multiplies.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_ctl <= r_s1_ctl;
            r_pr <= r_s1_ctl.en_right ? r_dr * $signed({1'b0, r_s1_cw}) : PROD_W'(0);
            r_pl <= r_s1_ctl.en_left  ? r_dl * $signed({1'b0, r_s1_lw}) : PROD_W'(0);
            r_pd <= r_s1_ctl.en_down  ? r_dd * $signed({1'b0, r_s1_cw}) : PROD_W'(0);
            r_pu <= r_s1_ctl.en_up    ? r_du * $signed({1'b0, r_s1_uw}) : PROD_W'(0);
        end
    end

    assign acc = ACC_W'(r_pl) + ACC_W'(r_pu) - ACC_W'(r_pr) - ACC_W'(r_pd);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_result <= RESULT_W'(acc);
            r_s3_row    <= r_s2_ctl.row;
            r_s3_col    <= r_s2_ctl.col;
            r_s3_done   <= r_s2_ctl.done;
        end
    end

    assign o_res_valid = r_s3_valid;
    assign o_result    = r_s3_result;
    assign o_row       = r_s3_row;
    assign o_col       = r_s3_col;
    assign o_done      = r_s3_done;

    a_stage_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_s2_valid) |=> r_s3_valid)
        else $error("product stage dropped a request");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> ($stable(r_s1_valid) && $stable(r_s2_valid)))
        else $error("pipeline moved during output stall");

endmodule

@@ hdl/weighted_laplacian_stencil_unit.sv @@
// Each result passes the front end's pixel register, the task queue and the back end.
// Throughput: one pixel per cycle while the queue has room; on the last row a pixel
// past column zero yields two results (one in a single-row frame) and the final pixel
// one more; the front end issues one request per cycle, so those pixels stall input.
// Reset (synchronous, active low): frame restarts at row 0, column 0, size 1024x1024
// clamped to the maximum; the two line buffer banks are left as they are.
module weighted_laplacian_stencil_unit import wls_pkg::*; #(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]                        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]                       i_cfg_data,
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    // sample, weight
    input  logic [((SAMPLE_BITS+WEIGHT_W+7)/8)*8-1:0]   s_axis_tdata,
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    // result, out_row, out_column
    output logic [OUT_TDATA_W-1:0]                      m_axis_tdata,
    output logic                                        m_axis_tlast
);

    localparam int OPND_W = 5 * SAMPLE_BITS + 3 * WEIGHT_W;

    logic              task_valid;
    logic              task_ready;
    t_task_ctl         task_ctl;
    logic [OPND_W-1:0] task_opnd;
    logic              q_full;
    logic              q_empty;
    logic              q_pop;
    t_task_ctl         q_ctl;
    logic [OPND_W-1:0] q_opnd;
    logic [RESULT_W-1:0] result;
    logic [TAG_W-1:0]    out_row;
    logic [TAG_W-1:0]    out_col;

    assign o_cfg_ready = 1'b1;
    assign task_ready  = !q_full;

    wls_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_sample     (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_weight     (s_axis_tdata[SAMPLE_BITS+WEIGHT_W-1:SAMPLE_BITS]),
        .o_task_valid (task_valid),
        .i_task_ready (task_ready),
        .o_task_ctl   (task_ctl),
        .o_task_opnd  (task_opnd)
    );

    wls_fifo #(
        .DATA_W (OPND_W)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (task_valid),
        .i_push_ctl  (task_ctl),
        .i_push_data (task_opnd),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_empty     (q_empty),
        .o_pop_ctl   (q_ctl),
        .o_pop_data  (q_opnd)
    );

    wls_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_task_valid (!q_empty),
        .o_task_pop   (q_pop),
        .i_task_ctl   (q_ctl),
        .i_task_opnd  (q_opnd),
        .o_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .o_result     (result),
        .o_row        (out_row),
        .o_col        (out_col),
        .o_done       (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_TDATA_W'({out_col, out_row, result});

endmodule
